// ----- hdl/dld_pkg.sv -----
// shared constants, status codes and control/status types of the decimal divider
package dld_pkg;

  localparam int DIGIT_W      = 4;
  localparam int FIELD_W      = 36;
  localparam int FIELD_DIGITS = FIELD_W / DIGIT_W;
  localparam int DIGITS_DEF   = 9;
  localparam int BASE_DEF     = 10;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_DIV_ZERO  = 2'd1;
  localparam logic [1:0] STATUS_BAD_DIGIT = 2'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic shift;
    logic sub;
    logic emit;
  } dld_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic bad;
    logic zero;
    logic fits;
    logic last;
  } dld_stat_t;

endpackage

// ----- hdl/dld_datapath.sv -----
// operand, partial remainder and quotient registers with the digit-wise subtractor
module dld_datapath import dld_pkg::*; #(
  parameter int DIGITS = DIGITS_DEF,
  parameter int BASE   = BASE_DEF
) (
  input  logic               clk,
  input  logic [FIELD_W-1:0] dividend,
  input  logic [FIELD_W-1:0] divisor,
  input  dld_cmd_t           cmd,
  output dld_stat_t          stat,
  output logic [FIELD_W-1:0] quotient,
  output logic [FIELD_W-1:0] remainder,
  output logic [1:0]         status
);

  localparam int PW = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam logic [PW-1:0] LAST_POS = PW'(DIGITS - 1);
  localparam logic [DIGIT_W:0] BASE_V = (DIGIT_W + 1)'(BASE);

  logic [DIGIT_W-1:0] in_num [DIGITS];
  logic [DIGIT_W-1:0] in_den [DIGITS];

  logic [DIGIT_W-1:0] num  [DIGITS];
  logic [DIGIT_W-1:0] den  [DIGITS];
  logic [DIGIT_W-1:0] quo  [DIGITS];
  logic [DIGIT_W-1:0] part [DIGITS+1];
  logic [DIGIT_W-1:0] diff [DIGITS+1];
  logic [DIGIT_W-1:0] q;
  logic [PW-1:0]      pos;

  logic [FIELD_W-1:0] quo_pk;
  logic [FIELD_W-1:0] rem_pk;
  logic               borrow_out;

  // unpack operands; digits beyond the field read as zero
  for (genvar i = 0; i < DIGITS; i++) begin : g_unpack
    if (i < FIELD_DIGITS) begin : g_in
      assign in_num[i] = dividend[DIGIT_W*i +: DIGIT_W];
      assign in_den[i] = divisor[DIGIT_W*i +: DIGIT_W];
    end else begin : g_zero
      assign in_num[i] = '0;
      assign in_den[i] = '0;
    end
  end

  // pack results into the field
  for (genvar i = 0; i < FIELD_DIGITS; i++) begin : g_pack
    if (i < DIGITS) begin : g_dig
      assign quo_pk[DIGIT_W*i +: DIGIT_W] = quo[i];
      assign rem_pk[DIGIT_W*i +: DIGIT_W] = part[i];
    end else begin : g_zero
      assign quo_pk[DIGIT_W*i +: DIGIT_W] = '0;
      assign rem_pk[DIGIT_W*i +: DIGIT_W] = '0;
    end
  end

  // operand checks and status towards the controller
  always_comb begin
    stat.bad  = 1'b0;
    stat.zero = 1'b1;
    for (int i = 0; i < DIGITS; i++) begin
      if ({1'b0, num[i]} >= BASE_V || {1'b0, den[i]} >= BASE_V) begin
        stat.bad = 1'b1;
      end
      if (den[i] != '0) begin
        stat.zero = 1'b0;
      end
    end
    stat.fits = ~borrow_out;
    stat.last = (pos == '0);
  end

  // digit-wise subtract part - den with borrow in the working radix
  always_comb begin
    logic             brw;
    logic [DIGIT_W:0] t;
    logic [DIGIT_W-1:0] d;
    brw = 1'b0;
    for (int i = 0; i <= DIGITS; i++) begin
      d = (i < DIGITS) ? den[i] : '0;
      t = {1'b0, part[i]} - {1'b0, d} - {{DIGIT_W{1'b0}}, brw};
      if (t[DIGIT_W]) begin
        diff[i] = t[DIGIT_W-1:0] + BASE_V[DIGIT_W-1:0];
        brw = 1'b1;
      end else begin
        diff[i] = t[DIGIT_W-1:0];
        brw = 1'b0;
      end
    end
    borrow_out = brw;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      num <= in_num;
      den <= in_den;
      for (int i = 0; i < DIGITS; i++) begin
        quo[i] <= '0;
      end
      for (int i = 0; i <= DIGITS; i++) begin
        part[i] <= '0;
      end
      pos <= LAST_POS;
      q   <= '0;
    end
    if (cmd.shift) begin
      for (int i = DIGITS; i > 0; i--) begin
        part[i] <= part[i-1];
      end
      part[0] <= num[pos];
      q       <= '0;
    end
    if (cmd.sub) begin
      if (~borrow_out) begin
        part <= diff;
        q    <= q + 1'b1;
      end else begin
        quo[pos] <= q;
        if (pos != '0) begin
          pos <= pos - 1'b1;
        end
      end
    end
    if (cmd.emit) begin
      if (stat.bad) begin
        quotient  <= '0;
        remainder <= '0;
        status    <= STATUS_BAD_DIGIT;
      end else if (stat.zero) begin
        quotient  <= '0;
        remainder <= '0;
        status    <= STATUS_DIV_ZERO;
      end else begin
        quotient  <= quo_pk;
        remainder <= rem_pk;
        status    <= STATUS_OK;
      end
    end
  end

endmodule

// ----- hdl/dld_ctrl.sv -----
// controller state machine sequencing the digit-serial long division
module dld_ctrl import dld_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  dld_stat_t stat,
  output dld_cmd_t  cmd,
  output logic      busy,
  output logic      done
);

  typedef enum logic [2:0] {
    IDLE,
    CHECK,
    SHIFT,
    SUB,
    FINISH
  } state_t;

  state_t state;

  assign busy = (state != IDLE);

  always_comb begin
    cmd.load  = (state == IDLE) && start;
    cmd.shift = (state == SHIFT);
    cmd.sub   = (state == SUB);
    cmd.emit  = (state == FINISH) || ((state == CHECK) && (stat.bad || stat.zero));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      done  <= 1'b0;
    end else begin
      done <= cmd.emit;
      case (state)
        IDLE: begin
          if (start) begin
            state <= CHECK;
          end
        end
        CHECK: begin
          if (stat.bad || stat.zero) begin
            state <= IDLE;
          end else begin
            state <= SHIFT;
          end
        end
        SHIFT: begin
          state <= SUB;
        end
        SUB: begin
          if (!stat.fits) begin
            state <= stat.last ? FINISH : SHIFT;
          end
        end
        FINISH: begin
          state <= IDLE;
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hdl/decimal_long_division.sv -----
// top level of the decimal long divider: controller plus datapath
//
// channel   direction  handshake            payload
// command   in         start, busy          dividend, divisor
// result    out        done (one cycle)     quotient, remainder, status
//
// a transaction is taken when start is high and busy is low
// each transaction passes the operand check, then per digit a shift and a run of
// subtractions, then the finish step that raises done; an operand error answers
// straight from the check
// the divider has a single compare-subtract unit, one step per cycle
// the result registers hold until the next result; done lasts one cycle and
// the receiver cannot stall it; a new transaction may be taken while done is high
// rst is synchronous and returns the controller to idle with no result pending
module decimal_long_division import dld_pkg::*; #(
  parameter int DIGITS = DIGITS_DEF,
  parameter int BASE   = BASE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [FIELD_W-1:0] dividend,
  input  logic [FIELD_W-1:0] divisor,
  output logic               done,
  output logic [FIELD_W-1:0] quotient,
  output logic [FIELD_W-1:0] remainder,
  output logic [1:0]         status
);

  dld_cmd_t  cmd;
  dld_stat_t stat;

  // sequencer: check operands, then per digit a shift and a run of subtractions
  dld_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // operand registers, partial remainder and the subtractor
  dld_datapath #(
    .DIGITS (DIGITS),
    .BASE   (BASE)
  ) u_datapath (
    .clk       (clk),
    .dividend  (dividend),
    .divisor   (divisor),
    .cmd       (cmd),
    .stat      (stat),
    .quotient  (quotient),
    .remainder (remainder),
    .status    (status)
  );

endmodule

// ----- bench/decimal_long_division_test.sv -----
`timescale 1ns / 100ps
// self-checking bench for the decimal long divider: directed corners, then random divisions
module decimal_long_division_test;
  import dld_pkg::*;

  localparam int DIGITS       = DIGITS_DEF;
  localparam int BASE         = BASE_DEF;
  // worst case accept-to-done time, plus a little slack
  localparam int TAIL_CYCLES  = DIGITS * (BASE + 1) + 8;
  localparam int RANDOM_ITEMS = 1050;

  typedef logic [FIELD_W-1:0] bcd_t;

  // one expected answer per accepted transaction
  typedef struct {
    bcd_t       quotient;
    bcd_t       remainder;
    logic [1:0] status;
  } answer_t;

  logic       clk      = 1'b0;
  logic       rst      = 1'b1;
  logic       start    = 1'b0;
  bcd_t       dividend = '0;
  bcd_t       divisor  = '0;
  logic       busy;
  logic       done;
  bcd_t       quotient;
  bcd_t       remainder;
  logic [1:0] status;

  answer_t pending_answers[$];
  int      failures = 0;
  int      n_ok     = 0;
  int      n_zero   = 0;
  int      n_bad    = 0;
  // upper bound of the sender's idle gap, switched per block of transactions
  int      gap_max  = 7;

  decimal_long_division #(
    .DIGITS(DIGITS),
    .BASE  (BASE)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (done),
    .quotient (quotient),
    .remainder(remainder),
    .status   (status)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // expected answer: operand digits checked first, then the zero divisor,
  // otherwise plain integer division of the decoded values, re-encoded digit by digit
  function automatic answer_t divide_bcd(bcd_t num, bcd_t den);
    answer_t         ans;
    longint unsigned a;
    longint unsigned b;
    longint unsigned q;
    longint unsigned r;
    logic [3:0]      nib;
    bit              digit_bad;
    ans.quotient  = '0;
    ans.remainder = '0;
    ans.status    = STATUS_OK;
    a = 0;
    b = 0;
    digit_bad = 1'b0;
    for (int i = DIGITS - 1; i >= 0; i--) begin
      nib = num[DIGIT_W*i +: DIGIT_W];
      if (nib >= BASE) digit_bad = 1'b1;
      a = a * BASE + nib;
      nib = den[DIGIT_W*i +: DIGIT_W];
      if (nib >= BASE) digit_bad = 1'b1;
      b = b * BASE + nib;
    end
    if (digit_bad) begin
      ans.status = STATUS_BAD_DIGIT;
    end else if (b == 0) begin
      ans.status = STATUS_DIV_ZERO;
    end else begin
      q = a / b;
      r = a % b;
      for (int i = 0; i < DIGITS; i++) begin
        ans.quotient[DIGIT_W*i +: DIGIT_W]  = 4'(q % BASE);
        ans.remainder[DIGIT_W*i +: DIGIT_W] = 4'(r % BASE);
        q = q / BASE;
        r = r / BASE;
      end
    end
    return ans;
  endfunction

  // valid operand with at most the given number of significant digits
  function automatic bcd_t random_bcd(int ndigits);
    bcd_t v;
    v = '0;
    for (int i = 0; i < ndigits; i++) v[DIGIT_W*i +: DIGIT_W] = 4'($urandom_range(0, BASE - 1));
    return v;
  endfunction

  // one command transaction; start stays high across back-to-back transactions so
  // that it never gets two updates in the same time step
  task automatic send_division(input bcd_t num, input bcd_t den);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    dividend <= num;
    divisor  <= den;
    do @(posedge clk); while (busy);
    pending_answers.push_back(divide_bcd(num, den));
  endtask

  // drop start and hold off until every outstanding result is back
  task automatic drain_answers();
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  // result checker: done is a one-cycle strobe, sampled at the edge that ends it
  always @(posedge clk) begin
    answer_t want;
    if (!rst && done) begin
      if (pending_answers.size() == 0) begin
        $error("result with no transaction outstanding: quotient %h remainder %h status %0d",
               quotient, remainder, status);
        failures++;
      end else begin
        want = pending_answers.pop_front();
        if (quotient !== want.quotient) begin
          $error("quotient mismatch: expected %h, got %h", want.quotient, quotient);
          failures++;
        end
        if (remainder !== want.remainder) begin
          $error("remainder mismatch: expected %h, got %h", want.remainder, remainder);
          failures++;
        end
        if (status !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, status);
          failures++;
        end
        case (want.status)
          STATUS_OK:       n_ok++;
          STATUS_DIV_ZERO: n_zero++;
          default:         n_bad++;
        endcase
      end
    end
  end

  // largest and smallest operands, quotient of all nines (longest run), equal
  // operands and a dividend below the divisor
  task automatic test_extremes();
    send_division(36'h000000000, 36'h000000001);
    send_division(36'h999999999, 36'h000000001);
    send_division(36'h999999999, 36'h999999999);
    send_division(36'h000000000, 36'h999999999);
    send_division(36'h000000001, 36'h999999999);
    send_division(36'h999999998, 36'h999999999);
    send_division(36'h100000000, 36'h000000001);
    send_division(36'h123456789, 36'h000000009);
    send_division(36'h999999999, 36'h000000002);
    send_division(36'h987654321, 36'h000012345);
  endtask

  // zero divisor, including a zero dividend and the largest dividend
  task automatic test_zero_divisor();
    send_division(36'h000000005, 36'h000000000);
    send_division(36'h000000000, 36'h000000000);
    send_division(36'h999999999, 36'h000000000);
  endtask

  // nibble above nine in either operand, at either end; a bad digit outranks
  // a zero divisor
  task automatic test_bad_digits();
    send_division(36'h00000000a, 36'h000000003);
    send_division(36'hf00000000, 36'h000000003);
    send_division(36'h000000007, 36'h00000000b);
    send_division(36'h000000007, 36'hc00000001);
    send_division(36'h00000000e, 36'h000000000);
    send_division(36'hfffffffff, 36'hfffffffff);
    drain_answers();
  endtask

  // mostly well-formed operands of random length, with small divisors for long
  // quotients, zero divisors, injected bad digits and raw bit patterns mixed in
  task automatic test_random();
    bcd_t num;
    bcd_t den;
    int   kind;
    int   pos;
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      // blocks of back-to-back transactions between blocks with idle gaps
      if (k % 50 == 0) gap_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
      if (k % 200 == 199) drain_answers();
      kind = $urandom_range(0, 99);
      num  = random_bcd($urandom_range(1, DIGITS));
      den  = random_bcd($urandom_range(1, DIGITS));
      if (kind < 20) begin
        den = random_bcd($urandom_range(1, 2));
      end else if (kind < 24) begin
        den = '0;
      end else if (kind < 32) begin
        pos = $urandom_range(0, DIGITS - 1);
        if ($urandom_range(0, 1) == 1) num[DIGIT_W*pos +: DIGIT_W] = 4'($urandom_range(BASE, 15));
        else                           den[DIGIT_W*pos +: DIGIT_W] = 4'($urandom_range(BASE, 15));
      end else if (kind < 37) begin
        num = bcd_t'({$urandom(), $urandom()});
        den = bcd_t'({$urandom(), $urandom()});
      end
      send_division(num, den);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_extremes();
    test_zero_divisor();
    test_bad_digits();
    test_random();
    start <= 1'b0;
    for (int w = 0; w < 4 * TAIL_CYCLES && pending_answers.size() != 0; w++) @(posedge clk);
    // watch for stray strobes after the last answer
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_answers.size() != 0) begin
      $error("%0d expected results never arrived", pending_answers.size());
      failures++;
    end
    $display("divisions checked: %0d with a quotient, %0d by zero, %0d with a bad digit",
             n_ok, n_zero, n_bad);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
